// ===== rtl/core/value_noise_pixel_grain_defines.svh =====
// Assertion macros for the value noise grain block.
`ifndef VALUE_NOISE_PIXEL_GRAIN_DEFINES_SVH
`define VALUE_NOISE_PIXEL_GRAIN_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked only while out of reset.
`define VNPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VNPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define VNPG_ASSERT(label, clk, rst_n, prop, msg)
`define VNPG_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/core/vnpg_pkg.sv =====
package vnpg_pkg;

    // pipeline depth, stage k+1 is loaded by enable bit k
    localparam int STAGES = 8;

    localparam int STEP_W = 25;
    localparam int FRAC_W = 16;
    localparam int CHAN_W = 16;
    localparam int AMT_W  = 16;

    typedef logic [STAGES-1:0] stage_en_t;

    // hash constants
    localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
    localparam logic [31:0] HASH_MUL_SEED = 32'd1103515245;
    localparam logic [31:0] HASH_MIX      = 32'd1274126177;

    // (seed + k) * HASH_MUL_SEED = seed * HASH_MUL_SEED + k * HASH_MUL_SEED
    localparam logic [63:0] SEED_PROD_G = 64'd100 * 64'd1103515245;
    localparam logic [63:0] SEED_PROD_B = 64'd200 * 64'd1103515245;
    localparam logic [31:0] SEED_TERM_G = SEED_PROD_G[31:0];
    localparam logic [31:0] SEED_TERM_B = SEED_PROD_B[31:0];

    // Q16 one and smoothstep constant 3.0
    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [17:0] SMOOTH_K = 18'd196608;

    localparam logic [CHAN_W-1:0] LIMIT_8  = 16'd255;
    localparam logic [CHAN_W-1:0] LIMIT_16 = 16'd32768;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_NOISE_SEED   = 3'd0,
        REG_COLOR_MODE   = 3'd1,
        REG_DEPTH_MODE   = 3'd2,
        REG_GRAIN_AMOUNT = 3'd3,
        REG_STEP_X       = 3'd4,
        REG_STEP_Y       = 3'd5
    } cfg_idx_t;

    // four corner values of one lattice cell, Q0.16
    typedef struct packed {
        logic [15:0] v00;
        logic [15:0] v10;
        logic [15:0] v01;
        logic [15:0] v11;
    } corner_set_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

endpackage

// ===== rtl/core/vnpg_lattice.sv =====
module vnpg_lattice #(
    parameter int COORD_BITS = 13
) (
    input  logic                        aclk,
    input  vnpg_pkg::stage_en_t         en,
    input  logic [COORD_BITS-1:0]       pixel_x,
    input  logic [COORD_BITS-1:0]       pixel_y,
    input  logic [vnpg_pkg::STEP_W-1:0] step_x,
    input  logic [vnpg_pkg::STEP_W-1:0] step_y,
    output logic [31:0]                 hx,
    output logic [31:0]                 hy,
    output logic [16:0]                 ux,
    output logic [16:0]                 uy
);

    localparam int POS_W = COORD_BITS + vnpg_pkg::STEP_W;
    localparam int CX_W  = POS_W - vnpg_pkg::FRAC_W;

    // stage 1: lattice position
    logic [POS_W-1:0] pos_x_reg, pos_y_reg;
    logic [POS_W-1:0] pos_x_next, pos_y_next;

    // stage 2: cell hash terms, fraction and its square
    logic [31:0]       hx_reg, hy_reg;
    logic [CX_W+31:0]  hx_prod, hy_prod;
    logic [15:0]       fx_reg, fy_reg;
    logic [15:0]       f2x_reg, f2y_reg;
    logic [31:0]       sqx, sqy;

    // stage 3: smoothstep weight
    logic [17:0] wx, wy;
    logic [33:0] ux_prod, uy_prod;
    logic [16:0] ux_reg, uy_reg;

    // stage 4: align with the corner values
    logic [16:0] ux_s4_reg, uy_s4_reg;

    assign pos_x_next = POS_W'(pixel_x) * POS_W'(step_x);
    assign pos_y_next = POS_W'(pixel_y) * POS_W'(step_y);

    assign hx_prod = (CX_W+32)'(pos_x_reg[POS_W-1:vnpg_pkg::FRAC_W]) *
                     (CX_W+32)'(vnpg_pkg::HASH_MUL_X);
    assign hy_prod = (CX_W+32)'(pos_y_reg[POS_W-1:vnpg_pkg::FRAC_W]) *
                     (CX_W+32)'(vnpg_pkg::HASH_MUL_Y);
    assign sqx = 32'(pos_x_reg[15:0]) * 32'(pos_x_reg[15:0]);
    assign sqy = 32'(pos_y_reg[15:0]) * 32'(pos_y_reg[15:0]);

    assign wx = vnpg_pkg::SMOOTH_K - {1'b0, fx_reg, 1'b0};
    assign wy = vnpg_pkg::SMOOTH_K - {1'b0, fy_reg, 1'b0};
    assign ux_prod = 34'(f2x_reg) * 34'(wx);
    assign uy_prod = 34'(f2y_reg) * 34'(wy);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
        if (en[1]) begin
            hx_reg  <= hx_prod[31:0];
            hy_reg  <= hy_prod[31:0];
            fx_reg  <= pos_x_reg[15:0];
            fy_reg  <= pos_y_reg[15:0];
            f2x_reg <= sqx[31:16];
            f2y_reg <= sqy[31:16];
        end
        if (en[2]) begin
            ux_reg <= ux_prod[32:16];
            uy_reg <= uy_prod[32:16];
        end
        if (en[3]) begin
            ux_s4_reg <= ux_reg;
            uy_s4_reg <= uy_reg;
        end
    end

    assign hx = hx_reg;
    assign hy = hy_reg;
    assign ux = ux_s4_reg;
    assign uy = uy_s4_reg;

endmodule

// ===== rtl/core/vnpg_hash.sv =====
module vnpg_hash (
    input  logic                  aclk,
    input  vnpg_pkg::stage_en_t   en,
    input  logic [31:0]           hx,
    input  logic [31:0]           hy,
    input  logic [31:0]           seed_term,
    output vnpg_pkg::corner_set_t corners
);

    // corner order: 0 = (x,y), 1 = (x+1,y), 2 = (x,y+1), 3 = (x+1,y+1)
    logic [31:0] hx1, hy1;
    logic [31:0] sum   [4];
    logic [31:0] mix_next [4];
    logic [31:0] mix_reg  [4];
    logic [63:0] prod  [4];
    logic [15:0] val   [4];
    vnpg_pkg::corner_set_t corners_reg;

    assign hx1 = hx + vnpg_pkg::HASH_MUL_X;
    assign hy1 = hy + vnpg_pkg::HASH_MUL_Y;

    assign sum[0] = hx  + hy  + seed_term;
    assign sum[1] = hx1 + hy  + seed_term;
    assign sum[2] = hx  + hy1 + seed_term;
    assign sum[3] = hx1 + hy1 + seed_term;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mix_next[i] = sum[i] ^ (sum[i] >> 13);
            prod[i]     = 64'(mix_reg[i]) * 64'(vnpg_pkg::HASH_MIX);
            // low 31 bits, top 16 of them
            val[i]      = prod[i][30:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int i = 0; i < 4; i++) begin
                mix_reg[i] <= mix_next[i];
            end
        end
        if (en[3]) begin
            corners_reg.v00 <= val[0];
            corners_reg.v10 <= val[1];
            corners_reg.v01 <= val[2];
            corners_reg.v11 <= val[3];
        end
    end

    assign corners = corners_reg;

endmodule

// ===== rtl/core/vnpg_blend.sv =====
module vnpg_blend (
    input  logic                  aclk,
    input  vnpg_pkg::stage_en_t   en,
    input  vnpg_pkg::corner_set_t corners,
    input  logic [16:0]           ux,
    input  logic [16:0]           uy,
    output logic [15:0]           noise
);

    logic [16:0] wx0, wy0;
    logic [32:0] a_sum, b_sum, n_sum;
    logic [15:0] a_reg, b_reg, n_reg;
    logic [16:0] uy_s5_reg;

    assign wx0 = vnpg_pkg::ONE_Q16 - ux;
    assign wy0 = vnpg_pkg::ONE_Q16 - uy_s5_reg;

    // each sum stays below 2^32
    assign a_sum = 33'(corners.v00) * 33'(wx0) + 33'(corners.v10) * 33'(ux);
    assign b_sum = 33'(corners.v01) * 33'(wx0) + 33'(corners.v11) * 33'(ux);
    assign n_sum = 33'(a_reg) * 33'(wy0) + 33'(b_reg) * 33'(uy_s5_reg);

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            a_reg     <= a_sum[31:16];
            b_reg     <= b_sum[31:16];
            uy_s5_reg <= uy;
        end
        if (en[5]) begin
            n_reg <= n_sum[31:16];
        end
    end

    assign noise = n_reg;

endmodule

// ===== rtl/core/vnpg_grain.sv =====
module vnpg_grain (
    input  logic                        aclk,
    input  vnpg_pkg::stage_en_t         en,
    input  logic [15:0]                 noise,
    input  logic [vnpg_pkg::CHAN_W-1:0] chan,
    input  logic                        depth_mode,
    input  logic [vnpg_pkg::AMT_W-1:0]  grain_amount,
    output logic [vnpg_pkg::CHAN_W-1:0] result
);

    // |2n - 1| in Q16, sign set when n is below one half
    logic        neg;
    logic [16:0] off_abs;
    logic [32:0] mag_next, mag_reg;
    logic        neg_reg;
    logic [vnpg_pkg::CHAN_W-1:0] chan_reg;

    logic [16:0]        delta;
    logic signed [17:0] chan_s, delta_s, sum_s, limit_s;
    logic [vnpg_pkg::CHAN_W-1:0] limit;
    logic [vnpg_pkg::CHAN_W-1:0] result_next, result_reg;

    assign neg     = !noise[15];
    assign off_abs = neg ? (vnpg_pkg::ONE_Q16 - {noise, 1'b0}) : {1'b0, noise[14:0], 1'b0};
    assign mag_next = 33'(off_abs) * 33'(grain_amount);

    always_comb begin
        delta   = depth_mode ? {1'b0, mag_reg[32:17]} : {8'b0, mag_reg[32:24]};
        limit   = depth_mode ? vnpg_pkg::LIMIT_16 : vnpg_pkg::LIMIT_8;
        chan_s  = signed'({2'b00, chan_reg});
        delta_s = signed'({1'b0, delta});
        limit_s = signed'({2'b00, limit});
        sum_s   = neg_reg ? (chan_s - delta_s) : (chan_s + delta_s);
        if (sum_s < 0) begin
            result_next = '0;
        end else if (sum_s > limit_s) begin
            result_next = limit;
        end else begin
            result_next = sum_s[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            mag_reg  <= mag_next;
            neg_reg  <= neg;
            chan_reg <= chan;
        end
        if (en[7]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/value_noise_pixel_grain.sv =====
// Film-grain value noise on a pixel stream. One pixel item (x, y, RGB) enters per clock and
// its result is formed through an eight-stage pipeline: lattice position
// multiply, cell hash terms and fraction square, smoothstep weight and hash mix, corner hash
// multiply, two bilinear blend stages, grain magnitude multiply, and add-and-clamp into the
// output register. Throughput is one item per clock, set by the fully pipelined multipliers
// (four per axis; four for the corner hashes and six for the blend per channel; one per
// channel for the grain); each stage holds under back-pressure and bubbles are squeezed out,
// so s_ready stays high while any stage is free. Registers are written over the cfg port
// (index 0 seed, 1 colour mode, 2 depth mode, 3 grain amount, 4 step x, 5 step y; other
// indexes ignored); the user must write them only while no pixel is in flight (the block
// does not enforce this); s_ready is held low in a cycle that carries a cfg write, and both
// s_ready and cfg_ready are low during reset. In mono mode all three channels share the
// noise of the base seed; in colour mode green and blue use seed + 100 and seed + 200.
`include "value_noise_pixel_grain_defines.svh"

module value_noise_pixel_grain #(
    parameter int COORD_BITS = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,

    // pixel in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_pixel_x,
    input  logic [COORD_BITS-1:0] s_pixel_y,
    input  logic [15:0]           s_in_red,
    input  logic [15:0]           s_in_green,
    input  logic [15:0]           s_in_blue,

    // pixel out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [15:0]           m_out_red,
    output logic [15:0]           m_out_green,
    output logic [15:0]           m_out_blue
);

    localparam int NS = vnpg_pkg::STAGES;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0]                   noise_seed_reg,   noise_seed_next;
    logic                          color_mode_reg,   color_mode_next;
    logic                          depth_mode_reg,   depth_mode_next;
    logic [vnpg_pkg::AMT_W-1:0]    grain_amount_reg, grain_amount_next;
    logic [vnpg_pkg::STEP_W-1:0]   step_x_reg,       step_x_next;
    logic [vnpg_pkg::STEP_W-1:0]   step_y_reg,       step_y_next;

    // writes are taken in any cycle out of reset
    assign cfg_ready = aresetn;

    always_comb begin
        noise_seed_next   = noise_seed_reg;
        color_mode_next   = color_mode_reg;
        depth_mode_next   = depth_mode_reg;
        grain_amount_next = grain_amount_reg;
        step_x_next       = step_x_reg;
        step_y_next       = step_y_reg;
        if (cfg_valid && cfg_ready) begin
            case (vnpg_pkg::cfg_idx_t'(cfg_index))
                vnpg_pkg::REG_NOISE_SEED:   noise_seed_next   = cfg_data;
                vnpg_pkg::REG_COLOR_MODE:   color_mode_next   = cfg_data[0];
                vnpg_pkg::REG_DEPTH_MODE:   depth_mode_next   = cfg_data[0];
                vnpg_pkg::REG_GRAIN_AMOUNT: grain_amount_next = cfg_data[vnpg_pkg::AMT_W-1:0];
                vnpg_pkg::REG_STEP_X:       step_x_next       = cfg_data[vnpg_pkg::STEP_W-1:0];
                vnpg_pkg::REG_STEP_Y:       step_y_next       = cfg_data[vnpg_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_seed_reg   <= '0;
            color_mode_reg   <= 1'b0;
            depth_mode_reg   <= 1'b0;
            grain_amount_reg <= '0;
            step_x_reg       <= vnpg_pkg::STEP_W'(65536);
            step_y_reg       <= vnpg_pkg::STEP_W'(65536);
        end else begin
            noise_seed_reg   <= noise_seed_next;
            color_mode_reg   <= color_mode_next;
            depth_mode_reg   <= depth_mode_next;
            grain_amount_reg <= grain_amount_next;
            step_x_reg       <= step_x_next;
            step_y_reg       <= step_y_next;
        end
    end

    // ---------------------------------------------------------------
    // Seed terms, refreshed every cycle from the seed register.
    // Registered in seed_term_reg, then seed_ch_reg; first used at the
    // stage 3 load, in the corner hash.
    // ---------------------------------------------------------------
    logic [63:0] seed_prod;
    logic [31:0] seed_term_reg;
    logic [31:0] seed_ch_reg [3];

    assign seed_prod = 64'(noise_seed_reg) * 64'(vnpg_pkg::HASH_MUL_SEED);

    always_ff @(posedge aclk) begin
        seed_term_reg  <= seed_prod[31:0];
        seed_ch_reg[0] <= seed_term_reg;
        seed_ch_reg[1] <= color_mode_reg ? (seed_term_reg + vnpg_pkg::SEED_TERM_G)
                                         : seed_term_reg;
        seed_ch_reg[2] <= color_mode_reg ? (seed_term_reg + vnpg_pkg::SEED_TERM_B)
                                         : seed_term_reg;
    end

    // ---------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its
    // successor loads, so bubbles close up under back-pressure.
    // ---------------------------------------------------------------
    vnpg_pkg::stage_en_t en;
    logic [NS-1:0]       vld_reg, vld_next;
    logic                in_acc, out_acc;

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    // no item enters in reset or in a cycle that writes configuration
    assign s_ready = aresetn && en[0] && !cfg_valid;
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        vld_next[0] = en[0] ? in_acc : vld_reg[0];
        for (int k = 1; k < NS; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign m_valid = vld_reg[NS-1];

    // ---------------------------------------------------------------
    // Channel values ride alongside until the grain stage (stages 1..6)
    // ---------------------------------------------------------------
    vnpg_pkg::rgb_t rgb_in;
    vnpg_pkg::rgb_t rgb_pipe_reg [6];

    assign rgb_in = '{red: s_in_red, green: s_in_green, blue: s_in_blue};

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rgb_pipe_reg[0] <= rgb_in;
        end
        for (int k = 1; k < 6; k++) begin
            if (en[k]) begin
                rgb_pipe_reg[k] <= rgb_pipe_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Lattice: cell hash terms (stage 2) and smoothstep weights (stage 4)
    // ---------------------------------------------------------------
    logic [31:0] hx, hy;
    logic [16:0] ux, uy;

    vnpg_lattice #(
        .COORD_BITS (COORD_BITS)
    ) u_lattice (
        .aclk    (aclk),
        .en      (en),
        .pixel_x (s_pixel_x),
        .pixel_y (s_pixel_y),
        .step_x  (step_x_reg),
        .step_y  (step_y_reg),
        .hx      (hx),
        .hy      (hy),
        .ux      (ux),
        .uy      (uy)
    );

    // ---------------------------------------------------------------
    // Per channel: corner hash, blend, grain
    // ---------------------------------------------------------------
    vnpg_pkg::corner_set_t corners [3];
    logic [15:0]           noise   [3];
    logic [15:0]           chan_in [3];
    logic [15:0]           result  [3];

    assign chan_in[0] = rgb_pipe_reg[5].red;
    assign chan_in[1] = rgb_pipe_reg[5].green;
    assign chan_in[2] = rgb_pipe_reg[5].blue;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        vnpg_hash u_hash (
            .aclk      (aclk),
            .en        (en),
            .hx        (hx),
            .hy        (hy),
            .seed_term (seed_ch_reg[c]),
            .corners   (corners[c])
        );

        vnpg_blend u_blend (
            .aclk    (aclk),
            .en      (en),
            .corners (corners[c]),
            .ux      (ux),
            .uy      (uy),
            .noise   (noise[c])
        );

        vnpg_grain u_grain (
            .aclk         (aclk),
            .en           (en),
            .noise        (noise[c]),
            .chan         (chan_in[c]),
            .depth_mode   (depth_mode_reg),
            .grain_amount (grain_amount_reg),
            .result       (result[c])
        );
    end

    assign m_out_red   = result[0];
    assign m_out_green = result[1];
    assign m_out_blue  = result[2];

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `VNPG_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> (vld_reg == '0), "pipeline not empty after reset")

    `VNPG_ASSERT(a_item_count, aclk, aresetn, $past(aresetn) |-> ($countones(vld_reg) == $past($countones(vld_reg)) + $past(32'(in_acc)) - $past(32'(out_acc))), "item lost or duplicated in pipeline")

    `VNPG_ASSERT(a_clamp_8bit, aclk, aresetn, (m_valid && !depth_mode_reg) |-> (m_out_red <= vnpg_pkg::LIMIT_8 && m_out_green <= vnpg_pkg::LIMIT_8 && m_out_blue <= vnpg_pkg::LIMIT_8), "8-bit result above 255")

    `VNPG_ASSERT(a_clamp_16bit, aclk, aresetn, m_valid |-> (m_out_red <= vnpg_pkg::LIMIT_16 && m_out_green <= vnpg_pkg::LIMIT_16 && m_out_blue <= vnpg_pkg::LIMIT_16), "result above 16-bit limit")

endmodule
